// File: src/br1bpd_pkg.sv
`default_nettype none

package br1bpd_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int COL_W    = 10;
    localparam int ROWB_W   = 11;
    localparam int ROW_W    = 11;
    localparam int ROWC_W   = 12;
    localparam int PLANE_W  = 4;
    localparam int IDX_W    = 3;
    localparam int CFGD_W   = 12;

    // register clamps
    localparam logic [ROWB_W-1:0]  ROW_BYTES_MAX = 11'd1024;
    localparam logic [ROWC_W-1:0]  ROWS_MAX      = 12'd2048;
    localparam logic [PLANE_W-1:0] PLANES_MAX    = 4'd8;

    // control byte that does nothing
    localparam logic [BYTE_W-1:0]  NOOP_CODE     = 8'd128;

    // register indexes
    localparam logic [IDX_W-1:0] REG_COMPRESSED  = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW_BYTES   = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW_COUNT   = 3'd2;
    localparam logic [IDX_W-1:0] REG_PLANE_COUNT = 3'd3;
    localparam logic [IDX_W-1:0] REG_HAS_MASK    = 3'd4;

    typedef struct packed {
        logic [ROWB_W-1:0]  row_bytes;
        logic [ROWC_W-1:0]  row_count;
        logic [PLANE_W-1:0] plane_count;
        logic               has_mask;
    } geom_t;

    typedef struct packed {
        logic              step;
        logic              restart;
        logic              emit;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] count;
        logic              spill;
    } place_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_value;
        logic [BYTE_W-1:0]  repeat_count;
        logic [PLANE_W-1:0] plane_index;
        logic [ROW_W-1:0]   row_index;
        logic [COL_W-1:0]   column_start;
        logic               discard;
        logic               row_plane_end;
        logic               image_end;
        logic               overrun;
    } run_t;

endpackage

`default_nettype wire

// File: src/byterun1_bitplane_decoder_core.sv
// ByteRun1 / raw bitplane body decoder.
// Body bytes come in one per transfer on the s_ channel (s_in_byte, with
// s_body_start high on the first byte of a body). Each byte gives at most one
// run on the m_ channel: a value, a repeat count and its place (plane, row,
// first column), with flags for mask plane, end of plane row, end of image
// and clipping at the row end. Control bytes and no-ops give no run.
// A byte is taken into an input register; once the output register can take
// it, it is decoded against the phase and position registers and its run lands
// in the output register, from which it shows on m_valid.
// One byte per cycle is sustained: the decode is a single pass of short
// logic, and both registers advance together whenever the output register
// is empty or is being taken.
// If the receiver stalls, the output register holds and the input register
// fills; s_ready drops only when both are full.
// The cfg channel is always ready; the user must write registers only while
// idle, not enforced by the block. Reset (aresetn low, synchronous) empties
// both registers, clears phase and position and loads the register defaults.
`default_nettype none

module byterun1_bitplane_decoder_core (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [br1bpd_pkg::BYTE_W-1:0]      s_in_byte,
    input  wire                                s_body_start,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [br1bpd_pkg::BYTE_W-1:0]      m_out_value,
    output logic [br1bpd_pkg::BYTE_W-1:0]      m_repeat_count,
    output logic [br1bpd_pkg::PLANE_W-1:0]     m_plane_index,
    output logic [br1bpd_pkg::ROW_W-1:0]       m_row_index,
    output logic [br1bpd_pkg::COL_W-1:0]       m_column_start,
    output logic                               m_discard,
    output logic                               m_row_plane_end,
    output logic                               m_image_end,
    output logic                               m_overrun,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [br1bpd_pkg::IDX_W-1:0]       cfg_index,
    input  wire  [br1bpd_pkg::CFGD_W-1:0]      cfg_data
);

    localparam logic [1:0] PH_CONTROL = 2'd0;
    localparam logic [1:0] PH_LITERAL = 2'd1;
    localparam logic [1:0] PH_REPEAT  = 2'd2;
    localparam logic [1:0] PH_SKIP    = 2'd3;

    logic                           compressed_reg;
    br1bpd_pkg::geom_t              geom_reg;

    logic                           in_valid_reg, in_valid_next;
    logic [br1bpd_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                           in_start_reg;

    logic [1:0]                     phase_reg, phase_next, phase_eff;
    logic [br1bpd_pkg::BYTE_W-1:0]  lit_reg, lit_next, lit_eff, lit_dec;
    logic [br1bpd_pkg::BYTE_W-1:0]  pend_reg, pend_next, pend_eff;

    logic                           out_valid_reg, out_valid_next;
    br1bpd_pkg::run_t               out_reg;

    br1bpd_pkg::place_req_t         req;
    br1bpd_pkg::run_t               run;
    logic                           run_ends, image_done;
    logic                           advance, step;
    logic [8:0]                     rep_len;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compressed_reg       <= 1'b1;
            geom_reg.row_bytes   <= 11'd40;
            geom_reg.row_count   <= 12'd200;
            geom_reg.plane_count <= 4'd5;
            geom_reg.has_mask    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                br1bpd_pkg::REG_COMPRESSED:  compressed_reg <= cfg_data[0];
                br1bpd_pkg::REG_ROW_BYTES:
                    geom_reg.row_bytes <= cfg_data[br1bpd_pkg::ROWB_W-1:0];
                br1bpd_pkg::REG_ROW_COUNT:   geom_reg.row_count <= cfg_data;
                br1bpd_pkg::REG_PLANE_COUNT:
                    geom_reg.plane_count <= cfg_data[br1bpd_pkg::PLANE_W-1:0];
                br1bpd_pkg::REG_HAS_MASK:    geom_reg.has_mask <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // decode of the registered byte
    always_comb begin
        phase_eff = in_start_reg ? PH_CONTROL : phase_reg;
        lit_eff   = in_start_reg ? '0 : lit_reg;
        pend_eff  = in_start_reg ? '0 : pend_reg;
        lit_dec   = lit_eff - 8'd1;
        rep_len   = 9'd257 - {1'b0, in_byte_reg};

        req.step    = step;
        req.restart = in_start_reg;
        req.emit    = 1'b0;
        req.value   = in_byte_reg;
        req.count   = 8'd1;
        req.spill   = 1'b0;

        phase_next = phase_reg;
        lit_next   = lit_reg;
        pend_next  = pend_reg;

        if (step) begin
            phase_next = phase_eff;
            lit_next   = lit_eff;
            pend_next  = pend_eff;
            if (!image_done) begin
                if (!compressed_reg) begin
                    req.emit   = 1'b1;
                    phase_next = PH_CONTROL;
                    lit_next   = '0;
                    pend_next  = '0;
                end else begin
                    unique case (phase_eff)
                        PH_CONTROL: begin
                            if (in_byte_reg < br1bpd_pkg::NOOP_CODE) begin
                                lit_next   = in_byte_reg + 8'd1;
                                phase_next = PH_LITERAL;
                            end else if (in_byte_reg > br1bpd_pkg::NOOP_CODE) begin
                                pend_next  = rep_len[br1bpd_pkg::BYTE_W-1:0];
                                phase_next = PH_REPEAT;
                            end
                        end
                        PH_LITERAL: begin
                            req.emit  = 1'b1;
                            req.spill = lit_dec != '0;
                            lit_next  = lit_dec;
                            if (lit_dec == '0) begin
                                phase_next = PH_CONTROL;
                            end else if (run_ends) begin
                                phase_next = PH_SKIP;
                            end
                        end
                        PH_REPEAT: begin
                            req.emit   = 1'b1;
                            req.count  = pend_eff;
                            pend_next  = '0;
                            phase_next = PH_CONTROL;
                        end
                        PH_SKIP: begin
                            // rest of a clipped literal run
                            lit_next = lit_dec;
                            if (lit_dec == '0) begin
                                phase_next = PH_CONTROL;
                            end
                        end
                        default: phase_next = PH_CONTROL;
                    endcase
                end
            end
        end

        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step && req.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    br1bpd_place u_place (
        .aclk    (aclk),
        .aresetn (aresetn),
        .geom    (geom_reg),
        .req     (req),
        .run     (run),
        .ends    (run_ends),
        .done    (image_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_CONTROL;
            lit_reg       <= '0;
            pend_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            lit_reg       <= lit_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_in_byte;
            in_start_reg <= s_body_start;
        end
        if (step && req.emit) begin
            out_reg <= run;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_value     = out_reg.out_value;
    assign m_repeat_count  = out_reg.repeat_count;
    assign m_plane_index   = out_reg.plane_index;
    assign m_row_index     = out_reg.row_index;
    assign m_column_start  = out_reg.column_start;
    assign m_discard       = out_reg.discard;
    assign m_row_plane_end = out_reg.row_plane_end;
    assign m_image_end     = out_reg.image_end;
    assign m_overrun       = out_reg.overrun;

    a_lit_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LITERAL || phase_reg == PH_SKIP) |-> lit_reg != '0)
        else $error("literal phase with no literals left");

    a_rep_len: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_REPEAT |-> (pend_reg >= 8'd2 && pend_reg <= 8'd128))
        else $error("repeat length out of range");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_repeat_count != '0 && m_repeat_count <= 8'd128))
        else $error("run with bad repeat count");

    a_end_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_image_end || m_overrun) |-> m_row_plane_end)
        else $error("image end or overrun without row end");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled with room to move");

endmodule

`default_nettype wire

// File: src/br1bpd_place.sv
`default_nettype none

module br1bpd_place (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  br1bpd_pkg::geom_t            geom,
    input  br1bpd_pkg::place_req_t       req,
    output br1bpd_pkg::run_t             run,
    output logic                         ends,
    output logic                         done
);

    logic [br1bpd_pkg::COL_W-1:0]   col_reg, col_next, col_eff;
    logic [br1bpd_pkg::PLANE_W-1:0] plane_reg, plane_next, plane_eff;
    logic [br1bpd_pkg::ROW_W-1:0]   row_reg, row_next, row_eff;
    logic                           done_reg, done_next, done_eff;

    logic [br1bpd_pkg::ROWB_W-1:0]  rb, avail;
    logic [br1bpd_pkg::ROWC_W-1:0]  rows, row_inc;
    logic [br1bpd_pkg::PLANE_W-1:0] planes, total;
    logic [br1bpd_pkg::PLANE_W:0]   plane_inc;
    logic [br1bpd_pkg::BYTE_W-1:0]  cnt;
    logic                           clip, plane_wrap, row_wrap;

    always_comb begin
        col_eff   = req.restart ? '0 : col_reg;
        plane_eff = req.restart ? '0 : plane_reg;
        row_eff   = req.restart ? '0 : row_reg;
        done_eff  = req.restart ? 1'b0 : done_reg;

        if (geom.row_bytes == '0) begin
            rb = 11'd1;
        end else if (geom.row_bytes > br1bpd_pkg::ROW_BYTES_MAX) begin
            rb = br1bpd_pkg::ROW_BYTES_MAX;
        end else begin
            rb = geom.row_bytes;
        end
        if (geom.row_count == '0) begin
            rows = 12'd1;
        end else if (geom.row_count > br1bpd_pkg::ROWS_MAX) begin
            rows = br1bpd_pkg::ROWS_MAX;
        end else begin
            rows = geom.row_count;
        end
        if (geom.plane_count == '0) begin
            planes = 4'd1;
        end else if (geom.plane_count > br1bpd_pkg::PLANES_MAX) begin
            planes = br1bpd_pkg::PLANES_MAX;
        end else begin
            planes = geom.plane_count;
        end
        total = planes + {3'b000, geom.has_mask};

        // a stale column past the row end still leaves one byte
        avail = ({1'b0, col_eff} < rb) ? rb - {1'b0, col_eff} : 11'd1;
        clip  = {3'b000, req.count} > avail;
        cnt   = clip ? avail[br1bpd_pkg::BYTE_W-1:0] : req.count;
        ends  = ({3'b000, cnt} == avail);

        plane_inc  = {1'b0, plane_eff} + 5'd1;
        plane_wrap = plane_inc >= {1'b0, total};
        row_inc    = {1'b0, row_eff} + 12'd1;
        row_wrap   = row_inc >= rows;

        run.out_value     = req.value;
        run.repeat_count  = cnt;
        run.plane_index   = plane_eff;
        run.row_index     = row_eff;
        run.column_start  = col_eff;
        run.discard       = plane_eff >= planes;
        run.row_plane_end = ends;
        run.image_end     = ends && plane_wrap && row_wrap;
        run.overrun       = clip || (ends && req.spill);

        done = done_eff;

        col_next   = col_reg;
        plane_next = plane_reg;
        row_next   = row_reg;
        done_next  = done_reg;
        if (req.step) begin
            col_next   = col_eff;
            plane_next = plane_eff;
            row_next   = row_eff;
            done_next  = done_eff;
            if (req.emit) begin
                if (ends) begin
                    col_next = '0;
                    if (plane_wrap) begin
                        plane_next = '0;
                        if (row_wrap) begin
                            row_next  = '0;
                            done_next = 1'b1;
                        end else begin
                            row_next = row_inc[br1bpd_pkg::ROW_W-1:0];
                        end
                    end else begin
                        plane_next = plane_inc[br1bpd_pkg::PLANE_W-1:0];
                    end
                end else begin
                    col_next = col_eff + {2'b00, cnt};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            plane_reg <= '0;
            row_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            col_reg   <= col_next;
            plane_reg <= plane_next;
            row_reg   <= row_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int BYTE_W  = br1bpd_pkg::BYTE_W;
    localparam int COL_W   = br1bpd_pkg::COL_W;
    localparam int ROWB_W  = br1bpd_pkg::ROWB_W;
    localparam int ROW_W   = br1bpd_pkg::ROW_W;
    localparam int ROWC_W  = br1bpd_pkg::ROWC_W;
    localparam int PLANE_W = br1bpd_pkg::PLANE_W;
    localparam int IDX_W   = br1bpd_pkg::IDX_W;
    localparam int CFGD_W  = br1bpd_pkg::CFGD_W;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_COUNT = 14;
    localparam int unsigned PHASE_ITEMS = 95;
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic [1:0] {
        WANT_CONTROL,
        COPY_LITERAL,
        WANT_REPEAT,
        DROP_LITERAL
    } body_phase_t;

    class run_tracker;
        bit compressed;
        int unsigned row_bytes, row_count, plane_count;
        bit has_mask;
        body_phase_t phase;
        int unsigned literal_left, repeat_len;
        int unsigned column_pos, plane_pos, row_pos;
        bit image_done;
        br1bpd_pkg::run_t pending_runs[$];
        int unsigned runs_seen, fail_count;

        function new();
            compressed = 1'b1;
            row_bytes = 40;
            row_count = 200;
            plane_count = 5;
            has_mask = 1'b0;
            runs_seen = 0;
            fail_count = 0;
            restart();
        endfunction

        function void restart();
            phase = WANT_CONTROL;
            literal_left = 0;
            repeat_len = 0;
            column_pos = 0;
            plane_pos = 0;
            row_pos = 0;
            image_done = 1'b0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFGD_W-1:0] data);
            case (idx)
                br1bpd_pkg::REG_COMPRESSED:  compressed = data[0];
                br1bpd_pkg::REG_ROW_BYTES:   row_bytes = data[ROWB_W-1:0];
                br1bpd_pkg::REG_ROW_COUNT:   row_count = data[ROWC_W-1:0];
                br1bpd_pkg::REG_PLANE_COUNT: plane_count = data[PLANE_W-1:0];
                br1bpd_pkg::REG_HAS_MASK:    has_mask = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        // queues one run at the current position and moves on; 1 if it closed the plane row
        function bit place_run(logic [BYTE_W-1:0] value, int unsigned count,
                               bit spill);
            int unsigned rb, rows, planes, total, avail;
            bit clipped, ends, last;
            br1bpd_pkg::run_t r;
            rb = clamp(row_bytes, 1, br1bpd_pkg::ROW_BYTES_MAX);
            rows = clamp(row_count, 1, br1bpd_pkg::ROWS_MAX);
            planes = clamp(plane_count, 1, br1bpd_pkg::PLANES_MAX);
            total = planes + has_mask;
            // a stale column past the row end leaves room for one byte
            avail = (column_pos < rb) ? rb - column_pos : 1;
            clipped = 1'b0;
            if (count > avail) begin
                count = avail;
                clipped = 1'b1;
            end
            ends = (count == avail);
            if (ends && spill) clipped = 1'b1;
            last = ends && plane_pos + 1 >= total && row_pos + 1 >= rows;
            r.out_value = value;
            r.repeat_count = BYTE_W'(count);
            r.plane_index = PLANE_W'(plane_pos);
            r.row_index = ROW_W'(row_pos);
            r.column_start = COL_W'(column_pos);
            r.discard = (plane_pos >= planes);
            r.row_plane_end = ends;
            r.image_end = last;
            r.overrun = clipped;
            pending_runs.push_back(r);
            if (ends) begin
                column_pos = 0;
                plane_pos++;
                if (plane_pos >= total) begin
                    plane_pos = 0;
                    row_pos++;
                    if (row_pos >= rows) begin
                        row_pos = 0;
                        image_done = 1'b1;
                    end
                end
            end else begin
                column_pos += count;
            end
            return ends;
        endfunction

        // notes one accepted body byte; 0 if the byte was ignored after the image end
        function bit take_byte(logic [BYTE_W-1:0] b, logic start);
            bit ends;
            if (start) restart();
            if (image_done) return 1'b0;
            if (!compressed) begin
                phase = WANT_CONTROL;
                literal_left = 0;
                repeat_len = 0;
                void'(place_run(b, 1, 1'b0));
                return 1'b1;
            end
            case (phase)
                WANT_CONTROL: begin
                    if (b < br1bpd_pkg::NOOP_CODE) begin
                        literal_left = b + 1;
                        phase = COPY_LITERAL;
                    end else if (b > br1bpd_pkg::NOOP_CODE) begin
                        repeat_len = 257 - int'(b);
                        phase = WANT_REPEAT;
                    end
                end
                COPY_LITERAL: begin
                    literal_left = (literal_left - 1) & 8'hFF;
                    ends = place_run(b, 1, literal_left != 0);
                    if (literal_left == 0) phase = WANT_CONTROL;
                    else if (ends) phase = DROP_LITERAL;
                end
                WANT_REPEAT: begin
                    void'(place_run(b, repeat_len, 1'b0));
                    repeat_len = 0;
                    phase = WANT_CONTROL;
                end
                default: begin
                    // rest of a literal run that was clipped at the row end
                    literal_left = (literal_left - 1) & 8'hFF;
                    if (literal_left == 0) phase = WANT_CONTROL;
                end
            endcase
            return 1'b1;
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            fail_count++;
            if (fail_count <= 40)
                $display("[%0t] run %0d %s: got %0d, expected %0d",
                         $time, runs_seen, what, got, want);
        endtask

        task check_run(br1bpd_pkg::run_t got);
            br1bpd_pkg::run_t want;
            runs_seen++;
            if (pending_runs.size() == 0) begin
                report("arrived with nothing pending, value", got.out_value, 0);
                return;
            end
            want = pending_runs.pop_front();
            if (got.out_value !== want.out_value)
                report("out_value", got.out_value, want.out_value);
            if (got.repeat_count !== want.repeat_count)
                report("repeat_count", got.repeat_count, want.repeat_count);
            if (got.plane_index !== want.plane_index)
                report("plane_index", got.plane_index, want.plane_index);
            if (got.row_index !== want.row_index)
                report("row_index", got.row_index, want.row_index);
            if (got.column_start !== want.column_start)
                report("column_start", got.column_start, want.column_start);
            if (got.discard !== want.discard)
                report("discard", got.discard, want.discard);
            if (got.row_plane_end !== want.row_plane_end)
                report("row_plane_end", got.row_plane_end, want.row_plane_end);
            if (got.image_end !== want.image_end)
                report("image_end", got.image_end, want.image_end);
            if (got.overrun !== want.overrun)
                report("overrun", got.overrun, want.overrun);
        endtask
    endclass

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_in_byte = '0;
    logic                s_body_start = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [BYTE_W-1:0]   m_out_value;
    logic [BYTE_W-1:0]   m_repeat_count;
    logic [PLANE_W-1:0]  m_plane_index;
    logic [ROW_W-1:0]    m_row_index;
    logic [COL_W-1:0]    m_column_start;
    logic                m_discard;
    logic                m_row_plane_end;
    logic                m_image_end;
    logic                m_overrun;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFGD_W-1:0]   cfg_data = '0;

    run_tracker tracker = new();
    int unsigned tx_max_gap = 0;
    int unsigned rx_max_stall = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;

    byterun1_bitplane_decoder_core DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // result side: check each transfer, then hold ready low for a drawn stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                tracker.check_run(br1bpd_pkg::run_t'{m_out_value, m_repeat_count,
                                                     m_plane_index, m_row_index,
                                                     m_column_start, m_discard,
                                                     m_row_plane_end, m_image_end,
                                                     m_overrun});
                stall_left = (rx_max_stall == 0) ? 0 : $urandom_range(0, rx_max_stall);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start, output bit taken);
        int unsigned gap;
        gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        s_body_start <= start;
        do @(posedge aclk); while (!s_ready);
        taken = tracker.take_byte(b, start);
    endtask

    // stop sending until every queued run is out, then let the pipeline empty
    task automatic settle(input int unsigned extra);
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending_runs.size() != 0);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFGD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_reg(idx, data);
    endtask

    // unused upper data bits carry noise, the block must mask them
    task automatic configure(input logic [5:0] which, input bit comp, input int unsigned rb,
                             input int unsigned rc, input int unsigned pc, input bit hm);
        logic [CFGD_W-1:0] junk;
        junk = CFGD_W'($urandom);
        if (which[0]) write_reg(br1bpd_pkg::REG_COMPRESSED, {junk[CFGD_W-1:1], comp});
        if (which[1]) write_reg(br1bpd_pkg::REG_ROW_BYTES, {junk[CFGD_W-1], rb[ROWB_W-1:0]});
        if (which[2]) write_reg(br1bpd_pkg::REG_ROW_COUNT, rc[ROWC_W-1:0]);
        if (which[3])
            write_reg(br1bpd_pkg::REG_PLANE_COUNT,
                      {junk[CFGD_W-1:PLANE_W], pc[PLANE_W-1:0]});
        if (which[4]) write_reg(br1bpd_pkg::REG_HAS_MASK, {junk[CFGD_W-1:1], hm});
        if (which[5]) write_reg(REG_UNUSED, junk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_bytes(input int unsigned target);
        int unsigned done_count, len, pick;
        bit taken, start;
        logic [BYTE_W-1:0] ctrl;
        done_count = 0;
        while (done_count < target) begin
            // a finished image swallows bytes until the next body start
            start = tracker.image_done || ($urandom_range(0, 39) == 0);
            pick = $urandom_range(0, 99);
            if (!tracker.compressed || pick >= 92) begin
                send_byte(BYTE_W'($urandom), start, taken);
                done_count += taken;
            end else if (pick < 45) begin
                len = $urandom_range(0, 39);
                if (len == 0) len = br1bpd_pkg::NOOP_CODE - 1;
                else if (len < 4) len = $urandom_range(0, br1bpd_pkg::NOOP_CODE - 1);
                else len = $urandom_range(0, 5);
                send_byte(BYTE_W'(len), start, taken);
                done_count += taken;
                repeat (len + 1) begin
                    send_byte(BYTE_W'($urandom), $urandom_range(0, 63) == 0, taken);
                    done_count += taken;
                end
            end else if (pick < 87) begin
                if ($urandom_range(0, 4) == 0)
                    ctrl = $urandom_range(0, 1) ? br1bpd_pkg::NOOP_CODE + 8'd1 : 8'hFF;
                else
                    ctrl = BYTE_W'($urandom_range(br1bpd_pkg::NOOP_CODE + 1, 255));
                send_byte(ctrl, start, taken);
                done_count += taken;
                send_byte(BYTE_W'($urandom), 1'b0, taken);
                done_count += taken;
            end else begin
                send_byte(br1bpd_pkg::NOOP_CODE, start, taken);
                done_count += taken;
            end
            if ($urandom_range(0, 149) == 0) settle(0);
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("byterun1_bitplane_decoder_core: mismatch");
        $finish;
    end

    initial begin
        bit taken;
        int unsigned ph;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults: two literals on a 40 byte row
        send_byte(8'h01, 1'b1, taken);
        send_byte(8'h00, 1'b0, taken);
        send_byte(8'hFF, 1'b0, taken);
        settle(4);

        // 4 byte rows, two rows, one plane plus mask
        configure(6'h1F, 1'b1, 4, 2, 1, 1'b1);
        tx_max_gap = 3;
        rx_max_stall = 3;
        send_byte(8'h00, 1'b1, taken);
        send_byte(8'hA5, 1'b0, taken);
        send_byte(br1bpd_pkg::NOOP_CODE, 1'b0, taken);
        send_byte(8'hFF, 1'b0, taken);
        send_byte(8'h00, 1'b0, taken);
        // longest repeat, clipped to the last column
        send_byte(br1bpd_pkg::NOOP_CODE + 8'd1, 1'b0, taken);
        send_byte(8'h3C, 1'b0, taken);
        send_byte(8'h02, 1'b0, taken);
        send_byte(8'h11, 1'b0, taken);
        send_byte(8'h22, 1'b0, taken);
        send_byte(8'h33, 1'b0, taken);
        // literal run spilling over the row end, second literal dropped
        send_byte(8'h01, 1'b0, taken);
        send_byte(8'h44, 1'b0, taken);
        send_byte(8'h55, 1'b0, taken);
        send_byte(8'hFD, 1'b0, taken);
        send_byte(8'h5A, 1'b0, taken);
        send_byte(8'hFD, 1'b0, taken);
        send_byte(8'hA5, 1'b0, taken);
        // image complete, the next two bytes are ignored, then a new body starts
        send_byte(8'h12, 1'b0, taken);
        send_byte(8'h34, 1'b0, taken);
        send_byte(br1bpd_pkg::NOOP_CODE, 1'b1, taken);
        send_byte(8'h00, 1'b0, taken);
        send_byte(8'h00, 1'b0, taken);
        settle(4);

        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph % 4)
                0: begin tx_max_gap = 0;  rx_max_stall = 0;  end
                1: begin tx_max_gap = 11; rx_max_stall = 0;  end
                2: begin tx_max_gap = 0;  rx_max_stall = 11; end
                default: begin tx_max_gap = 11; rx_max_stall = 11; end
            endcase
            case (ph)
                0: configure(6'h1F, 1'b1, 2, 1, 1, 1'b0);
                1: configure(6'h1F, 1'b0, 3, 2, 2, 1'b1);
                2: configure(6'h1F, 1'b1, br1bpd_pkg::ROW_BYTES_MAX, br1bpd_pkg::ROWS_MAX,
                             br1bpd_pkg::PLANES_MAX, 1'b1);
                // zero sizes clamp to one, stale position from the large image
                3: configure(6'h0E, 1'b1, 0, 0, 0, 1'b0);
                4: configure(6'h0E, 1'b1, 2047, 4095, 15, 1'b0);
                5: configure(6'h3F, 1'b1, 5, 3, 3, 1'b1);
                default: configure(6'($urandom), $urandom_range(0, 3) != 0,
                                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                               : $urandom_range(2, 12),
                                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                               : $urandom_range(1, 4),
                                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                               : $urandom_range(1, 4),
                                   $urandom_range(0, 1));
            endcase
            run_random_bytes(PHASE_ITEMS);
            settle(4);
        end

        repeat (8) @(posedge aclk);
        if (tracker.fail_count == 0)
            $display("byterun1_bitplane_decoder_core: match");
        else
            $display("byterun1_bitplane_decoder_core: mismatch");
        $finish;
    end

endmodule

// File: byterun1_bitplane_decoder_core.f
src/br1bpd_pkg.sv
src/br1bpd_place.sv
src/byterun1_bitplane_decoder_core.sv
tb/tb.sv
